@@ src/sorted_list_insert_remove_macros.svh @@
// Assertion macros for the checker file of the sorted list block.
// No dependencies; include by bare file name.
`ifndef SORTED_LIST_INSERT_REMOVE_MACROS_SVH
`define SORTED_LIST_INSERT_REMOVE_MACROS_SVH

// Same-cycle implication, checked on the rising clock edge outside reset
`define SLIR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sorted list check failed");

// Next-cycle implication, checked on the rising clock edge outside reset
`define SLIR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sorted list check failed");

`endif

@@ src/slir_pkg.sv @@
// Shared types and constants for the sorted list block.
// No dependencies; imported by the cell, the top level and the checker.
package slir_pkg;

    localparam int SLIR_DEPTH = 16;
    localparam int DATA_W     = 32;
    localparam int COUNT_W    = 5;
    localparam int CMD_W      = 2;
    localparam int STAT_W     = 2;

    // Input command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_INS  = 2'd0,
        CMD_REM  = 2'd1,
        CMD_READ = 2'd2
    } t_cmd;

    // Result status codes
    typedef enum logic [STAT_W-1:0] {
        STAT_OK       = 2'd0,
        STAT_EMPTY    = 2'd1,
        STAT_NOTFOUND = 2'd2,
        STAT_FULL     = 2'd3
    } t_status;

    // Operation broadcast to every cell of the chain
    typedef enum logic [1:0] {
        CELL_HOLD = 2'd0,
        CELL_INS  = 2'd1,
        CELL_REM  = 2'd2,
        CELL_ROT  = 2'd3
    } t_cell_op;

    typedef struct packed {
        t_cell_op                  op;
        logic signed [DATA_W-1:0]  value;
    } t_cell_ctl;

endpackage

@@ src/sorted_list_insert_remove.sv @@
// Top level of the sorted list: stream ports, sequencer and the chain of cells.
// Depends on slir_pkg and slir_cell.
//
// Usage: one command word enters on the slave stream (tuser = command,
// tdata = value). Insert and remove broadcast one operation along the cell
// chain; every cell decides locally from its own compare and its left or
// right neighbor, so the whole list moves at once. An insert or remove
// passes through the execute state before its result word is registered.
// A read rotates the valid cells by one position per cycle and emits the
// head cell, so a list of N entries gives N result words, the last with
// tlast. Command code 3 is taken and dropped without a result.
// Master words carry tuser = status, tdata = {count, entry}.
// A new command is taken only once the previous one has issued all its
// words; a finished word may still wait in the output register meanwhile.
// If the receiver stalls, the output register holds its word and the chain
// stops rotating until the word is taken.
// Reset (i_rst_n low, synchronous) empties the list and drops any
// pending output word.
module sorted_list_insert_remove import slir_pkg::*; #(
    parameter int DEPTH = SLIR_DEPTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [DATA_W-1:0]    i_s_axis_tdata,   // [31:0] value
    input  logic [CMD_W-1:0]     i_s_axis_tuser,   // [1:0] command
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    output logic [39:0]          o_m_axis_tdata,   // [31:0] entry, [36:32] count
    output logic [STAT_W-1:0]    o_m_axis_tuser,   // [1:0] status
    output logic                 o_m_axis_tlast    // last word of this command
);

    localparam int OCC_W = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_READ
    } t_state;

    t_state                    r_state;
    t_cmd                      r_cmd;
    logic signed [DATA_W-1:0]  r_value;
    logic [OCC_W-1:0]          r_occ;
    logic [OCC_W-1:0]          r_rd_cnt;
    logic                      r_ovalid;
    t_status                   r_ostatus;
    logic [DATA_W-1:0]         r_oentry;
    logic                      r_olast;
    logic [COUNT_W-1:0]        r_ocount;

    t_cell_ctl                 w_ctl;
    logic                      w_slot;
    logic                      w_full;
    logic                      w_found;
    logic                      w_rd_last;

    logic signed [DATA_W-1:0]  w_val   [DEPTH];
    logic                      w_vld   [DEPTH];
    logic                      w_ge    [DEPTH];
    logic [DEPTH-1:0]          w_match;

    // Output register is free when empty or being taken
    assign w_slot    = !r_ovalid || i_m_axis_tready;
    assign w_full    = (r_occ == OCC_W'(DEPTH));
    assign w_found   = |w_match;
    assign w_rd_last = (r_rd_cnt == r_occ - OCC_W'(1));

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = {3'b000, r_ocount, r_oentry};
    assign o_m_axis_tuser  = r_ostatus;
    assign o_m_axis_tlast  = r_olast;

    // Drive the chain operation from the sequencer state
    always_comb begin
        w_ctl.value = r_value;
        w_ctl.op    = CELL_HOLD;
        if (w_slot) begin
            if (r_state == S_EXEC) begin
                if (r_cmd == CMD_INS && !w_full) begin
                    w_ctl.op = CELL_INS;
                end else if (r_cmd == CMD_REM && w_found) begin
                    w_ctl.op = CELL_REM;
                end
            end else if (r_state == S_READ) begin
                w_ctl.op = CELL_ROT;
            end
        end
    end

    // Chain of cells, each wired to its neighbors
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic signed [DATA_W-1:0] w_lval;
        logic                     w_lvld;
        logic                     w_lge;
        logic signed [DATA_W-1:0] w_rval;
        logic                     w_rvld;

        if (g == 0) begin : g_head
            assign w_lval = '0;
            assign w_lvld = 1'b1;
            assign w_lge  = 1'b0;
        end else begin : g_body
            assign w_lval = w_val[g-1];
            assign w_lvld = w_vld[g-1];
            assign w_lge  = w_ge[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            assign w_rval = '0;
            assign w_rvld = 1'b0;
        end else begin : g_inner
            assign w_rval = w_val[g+1];
            assign w_rvld = w_vld[g+1];
        end

        slir_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (w_ctl),
            .i_left_val  (w_lval),
            .i_left_vld  (w_lvld),
            .i_left_ge   (w_lge),
            .i_right_val (w_rval),
            .i_right_vld (w_rvld),
            .i_head_val  (w_val[0]),
            .o_val       (w_val[g]),
            .o_vld       (w_vld[g]),
            .o_ge        (w_ge[g]),
            .o_match     (w_match[g])
        );
    end

    // Sequencer, occupancy and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_occ    <= '0;
            r_rd_cnt <= '0;
            r_ovalid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    // Drop a word once it is taken
                    if (i_m_axis_tready) begin
                        r_ovalid <= 1'b0;
                    end
                    if (i_s_axis_tvalid) begin
                        r_cmd   <= t_cmd'(i_s_axis_tuser);
                        r_value <= i_s_axis_tdata;
                        if (i_s_axis_tuser == CMD_INS || i_s_axis_tuser == CMD_REM ||
                            i_s_axis_tuser == CMD_READ) begin
                            r_state <= S_EXEC;
                        end
                    end
                end
                S_EXEC: begin
                    if (w_slot) begin
                        r_oentry <= '0;
                        r_olast  <= 1'b1;
                        case (r_cmd)
                            CMD_INS: begin
                                r_state  <= S_IDLE;
                                r_ovalid <= 1'b1;
                                if (w_full) begin
                                    r_ostatus <= STAT_FULL;
                                    r_ocount  <= COUNT_W'(r_occ);
                                end else begin
                                    r_ostatus <= STAT_OK;
                                    r_occ     <= r_occ + OCC_W'(1);
                                    r_ocount  <= COUNT_W'(r_occ + OCC_W'(1));
                                end
                            end
                            CMD_REM: begin
                                r_state  <= S_IDLE;
                                r_ovalid <= 1'b1;
                                if (r_occ == '0) begin
                                    r_ostatus <= STAT_EMPTY;
                                    r_ocount  <= COUNT_W'(r_occ);
                                end else if (!w_found) begin
                                    r_ostatus <= STAT_NOTFOUND;
                                    r_ocount  <= COUNT_W'(r_occ);
                                end else begin
                                    r_ostatus <= STAT_OK;
                                    r_occ     <= r_occ - OCC_W'(1);
                                    r_ocount  <= COUNT_W'(r_occ - OCC_W'(1));
                                end
                            end
                            default: begin
                                r_rd_cnt <= '0;
                                if (r_occ == '0) begin
                                    r_state   <= S_IDLE;
                                    r_ovalid  <= 1'b1;
                                    r_ostatus <= STAT_EMPTY;
                                    r_ocount  <= COUNT_W'(r_occ);
                                end else begin
                                    // Leave the emission to the read state
                                    r_state  <= S_READ;
                                    r_ovalid <= 1'b0;
                                end
                            end
                        endcase
                    end
                end
                S_READ: begin
                    if (w_slot) begin
                        r_ovalid  <= 1'b1;
                        r_ostatus <= STAT_OK;
                        r_oentry  <= w_val[0];
                        r_olast   <= w_rd_last;
                        r_ocount  <= COUNT_W'(r_occ);
                        r_rd_cnt  <= r_rd_cnt + OCC_W'(1);
                        if (w_rd_last) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

@@ src/slir_cell.sv @@
// One position of the sorted chain: holds a value and its valid flag.
// Depends on slir_pkg; exchanges values with its left and right neighbors.
module slir_cell import slir_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_cell_ctl                 i_ctl,
    input  logic signed [DATA_W-1:0]  i_left_val,
    input  logic                      i_left_vld,
    input  logic                      i_left_ge,
    input  logic signed [DATA_W-1:0]  i_right_val,
    input  logic                      i_right_vld,
    input  logic signed [DATA_W-1:0]  i_head_val,
    output logic signed [DATA_W-1:0]  o_val,
    output logic                      o_vld,
    output logic                      o_ge,
    output logic                      o_match
);

    logic signed [DATA_W-1:0] r_val;
    logic                     r_vld;
    logic                     w_keep;

    // New value goes at or before this cell unless this cell is strictly greater
    assign o_ge    = !(r_vld && (i_ctl.value < r_val));
    assign o_match = r_vld && (r_val == i_ctl.value);
    // On remove, strictly greater entries stay, the rest shift left
    assign w_keep  = r_vld && (r_val > i_ctl.value);

    assign o_val = r_val;
    assign o_vld = r_vld;

    // Apply the broadcast operation
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            case (i_ctl.op)
                CELL_INS: begin
                    if (o_ge) begin
                        r_val <= i_left_ge ? i_left_val : i_ctl.value;
                        r_vld <= i_left_ge ? i_left_vld : 1'b1;
                    end
                end
                CELL_REM: begin
                    if (r_vld && !w_keep) begin
                        r_val <= i_right_val;
                        r_vld <= i_right_vld;
                    end
                end
                CELL_ROT: begin
                    if (r_vld) begin
                        r_val <= i_right_vld ? i_right_val : i_head_val;
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule

@@ src/slir_checker.sv @@
// Port-level checks for the sorted list block, bound to its top level.
// Depends on slir_pkg and sorted_list_insert_remove_macros.svh.
`include "sorted_list_insert_remove_macros.svh"

module slir_port_checks import slir_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_axis_tvalid,
    input  logic                 o_s_axis_tready,
    input  logic [DATA_W-1:0]    i_s_axis_tdata,
    input  logic [CMD_W-1:0]     i_s_axis_tuser,
    input  logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    input  logic [39:0]          o_m_axis_tdata,
    input  logic [STAT_W-1:0]    o_m_axis_tuser,
    input  logic                 o_m_axis_tlast
);

    // A stalled word holds its contents
    `SLIR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n,
        o_m_axis_tvalid && !i_m_axis_tready,
        o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)
            && $stable(o_m_axis_tlast))

    // Only read-out words come without tlast, and they are always ok
    `SLIR_ASSERT_IMPL(a_mid_ok, i_clk, i_rst_n,
        o_m_axis_tvalid && !o_m_axis_tlast, o_m_axis_tuser == STAT_OK)

    // An error status ends the command and carries no entry
    `SLIR_ASSERT_IMPL(a_err_zero, i_clk, i_rst_n,
        o_m_axis_tvalid && o_m_axis_tuser != STAT_OK,
        o_m_axis_tlast && o_m_axis_tdata[DATA_W-1:0] == '0)

    // No new command while a read-out is still in progress
    `SLIR_ASSERT_IMPL(a_read_busy, i_clk, i_rst_n,
        o_m_axis_tvalid && !o_m_axis_tlast, !o_s_axis_tready)

endmodule

bind sorted_list_insert_remove slir_port_checks u_slir_checker (.*);
